// File: sv/rgbf_pkg.sv
// ----------------------------------------------------------------------------
// rgbf_pkg
// shared constants and control types for the rgb555 fade-to-color block
// ----------------------------------------------------------------------------
package rgbf_pkg;

  localparam int FRACTION_BITS = 12;

  localparam int PIX_W     = 16;
  localparam int CH_W      = 5;
  localparam int COLOR_W   = 8;
  localparam int CFG_IDX_W = 2;
  localparam int STEP_W    = 8;

  // blend factor, complement and products
  localparam int FACT_W    = FRACTION_BITS;
  localparam int COMP_W    = FRACTION_BITS + 1;
  localparam int PROD_W    = FRACTION_BITS + COLOR_W + 1;
  localparam int REM_W     = STEP_W + 1;

  // serial divider: a load step, then one quotient bit per cycle
  localparam int DIV_CNT_W = $clog2(FRACTION_BITS + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEPS   = 2'd3;

  localparam logic [STEP_W-1:0] FADE_STEPS_RESET = 8'd1;

  typedef struct packed {
    logic accept;
    logic cfg_we;
    logic div_load;
    logic div_iter;
  } rgbf_cmd_t;

  typedef struct packed {
    logic adv;
    logic adv_req;
  } rgbf_sts_t;

endpackage

// File: sv/rgbf_ctrl.sv
// ----------------------------------------------------------------------------
// rgbf_ctrl
// handshake control and sequencing of the serial blend-factor divider
// ----------------------------------------------------------------------------
module rgbf_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  rgbf_pkg::rgbf_sts_t                sts,
  output rgbf_pkg::rgbf_cmd_t                cmd
);
  import rgbf_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DIV  = 1'b1;

  localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(FRACTION_BITS);

  logic                 state_r, state_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 start;

  assign in_tready = (state_r == ST_IDLE) && sts.adv;
  assign cfg_ready = (state_r == ST_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.accept   = in_tvalid && in_tready;
    cmd.cfg_we   = cfg_valid && cfg_ready;
    cmd.div_load = (state_r == ST_DIV) && (cnt_r == '0);
    cmd.div_iter = (state_r == ST_DIV) && (cnt_r != '0);
    start        = (cmd.accept && sts.adv_req) ||
                   (cmd.cfg_we && (cfg_index == REG_FADE_STEPS));
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (start) begin
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        if (cnt_r == DIV_LAST) begin
          state_nxt = ST_IDLE;
          cnt_nxt   = '0;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

// File: sv/rgbf_dp.sv
// ----------------------------------------------------------------------------
// rgbf_dp
// config registers, step counter, serial divider and two-stage blend pipeline
// ----------------------------------------------------------------------------
module rgbf_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rgbf_pkg::rgbf_cmd_t                cmd,
  output rgbf_pkg::rgbf_sts_t                sts,
  input  logic [rgbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbf_pkg::COLOR_W-1:0]       cfg_data,
  input  logic [rgbf_pkg::PIX_W-1:0]         in_pixel,
  input  logic                               in_last,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rgbf_pkg::PIX_W-1:0]         out_pixel,
  output logic                               out_last,
  output logic                               out_final
);
  import rgbf_pkg::*;

  logic [COLOR_W-1:0] red_r, green_r, blue_r, steps_r;
  logic [STEP_W-1:0]  step_r;
  logic [REM_W-1:0]   rem_r, rem_nxt;
  logic [FACT_W-1:0]  quo_r;
  logic               quo_bit;
  logic [REM_W:0]     rem_sh;

  logic [COLOR_W-1:0] divr;
  logic [REM_W-1:0]   step_inc;
  logic               fin;
  logic [COMP_W-1:0]  comp;
  logic [COLOR_W-1:0] tgt [3];
  logic [PROD_W-1:0]  pa [3];
  logic [PROD_W-1:0]  pb [3];

  logic               s1_valid_r;
  logic               s1_zero_r, s1_fin_r, s1_flag_r, s1_last_r;
  logic [PROD_W-1:0]  s1_pa_r [3];
  logic [PROD_W-1:0]  s1_pb_r [3];

  logic               out_valid_r;
  logic [PIX_W-1:0]   out_pixel_r, out_pixel_nxt;
  logic               out_last_r, out_final_r;
  logic [PROD_W-1:0]  sum;
  logic               adv;

  assign divr     = (steps_r == '0) ? FADE_STEPS_RESET : steps_r;
  assign step_inc = {1'b0, step_r} + 1'b1;
  assign fin      = step_inc >= {1'b0, divr};
  assign adv      = !out_valid_r || out_ready;

  assign sts = '{adv: adv, adv_req: in_last && !fin};

  // config registers and step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= '0;
      green_r <= '0;
      blue_r  <= '0;
      steps_r <= FADE_STEPS_RESET;
      step_r  <= '0;
    end else begin
      if (cmd.cfg_we) begin
        case (cfg_index)
          REG_TARGET_RED:   red_r   <= cfg_data;
          REG_TARGET_GREEN: green_r <= cfg_data;
          REG_TARGET_BLUE:  blue_r  <= cfg_data;
          REG_FADE_STEPS:   steps_r <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.accept && in_last && !fin) begin
        step_r <= step_r + 1'b1;
      end
    end
  end

  // restoring divider: ((step+1) << FRACTION_BITS) / steps
  always_comb begin
    rem_sh  = {rem_r, 1'b0};
    quo_bit = rem_sh >= {2'b00, divr};
    rem_nxt = quo_bit ? REM_W'(rem_sh - {2'b00, divr}) : REM_W'(rem_sh);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_load) begin
      rem_r <= step_inc;
    end else if (cmd.div_iter) begin
      rem_r <= rem_nxt;
      quo_r <= {quo_r[FACT_W-2:0], quo_bit};
    end
  end

  // stage 1: channel products
  always_comb begin
    comp   = {1'b1, {FACT_W{1'b0}}} - {1'b0, quo_r};
    tgt[0] = red_r;
    tgt[1] = green_r;
    tgt[2] = blue_r;
    for (int i = 0; i < 3; i++) begin
      pa[i] = PROD_W'({in_pixel[CH_W*i +: CH_W], 3'b000} * comp);
      pb[i] = PROD_W'(tgt[i] * quo_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= cmd.accept;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && cmd.accept) begin
      s1_zero_r <= (in_pixel == '0);
      s1_fin_r  <= fin;
      s1_flag_r <= in_pixel[PIX_W-1];
      s1_last_r <= in_last;
      for (int i = 0; i < 3; i++) begin
        s1_pa_r[i] <= pa[i];
        s1_pb_r[i] <= pb[i];
      end
    end
  end

  // stage 2: sum, scale back and pack, or pass zero pixels and the target color
  always_comb begin
    out_pixel_nxt = {s1_flag_r, {(PIX_W-1){1'b0}}};
    sum           = '0;
    for (int i = 0; i < 3; i++) begin
      sum = s1_pa_r[i] + s1_pb_r[i];
      out_pixel_nxt[CH_W*i +: CH_W] = sum[FRACTION_BITS+3 +: CH_W];
    end
    if (s1_zero_r) begin
      out_pixel_nxt = '0;
    end else if (s1_fin_r) begin
      out_pixel_nxt = {1'b1, blue_r[COLOR_W-1 -: CH_W], green_r[COLOR_W-1 -: CH_W],
                       red_r[COLOR_W-1 -: CH_W]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_pixel_r <= out_pixel_nxt;
      out_last_r  <= s1_last_r;
      out_final_r <= s1_fin_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_last  = out_last_r;
  assign out_final = out_final_r;

endmodule

// File: sv/rgb555_fade_to_color_core.sv
// ----------------------------------------------------------------------------
// rgb555_fade_to_color_core
// fades a stream of rgb555 pixels toward a configured target color
// ----------------------------------------------------------------------------
// Pixels enter one per cycle unless held off or stalled, and leave in order.
// After an item marked tlast that is not in the final frame, and after a
// write to fade_steps, the input and config ports are held off while the
// bit-serial divider recomputes the blend factor, one quotient bit a cycle.
// Zero pixels pass unchanged; in the final frame every non-zero pixel
// becomes the target color with bit 15 set, and out_tuser flags that frame.
module rgb555_fade_to_color_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [15:0]                        in_tdata,   // pixel_in
  input  logic                               in_tlast,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [15:0]                        out_tdata,  // pixel_out
  output logic                               out_tlast,
  output logic [0:0]                         out_tuser,  // final_step
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rgbf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rgbf_pkg::COLOR_W-1:0]       cfg_data
);
  import rgbf_pkg::*;

  rgbf_cmd_t cmd;
  rgbf_sts_t sts;

  rgbf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .sts       (sts),
    .cmd       (cmd)
  );

  rgbf_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_pixel  (in_tdata),
    .in_last   (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_pixel (out_tdata),
    .out_last  (out_tlast),
    .out_final (out_tuser[0])
  );

endmodule

// File: sv/rgbf_chk.sv
// ----------------------------------------------------------------------------
// rgbf_chk
// port-level checks for the rgb555 fade-to-color block
// ----------------------------------------------------------------------------
module rgbf_chk (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tready,
  input  logic                               out_tvalid,
  input  logic                               out_tready,
  input  logic [15:0]                        out_tdata,
  input  logic                               out_tlast,
  input  logic [0:0]                         out_tuser,
  input  logic                               cfg_valid,
  input  logic                               cfg_ready,
  input  logic [rgbf_pkg::CFG_IDX_W-1:0]     cfg_index
);
  import rgbf_pkg::*;

  // a fade_steps write starts a divide that holds off input
  a_steps_div: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == REG_FADE_STEPS) |=> !in_tready)
    else $error("input taken right after fade_steps write");

  // while config is held off the divider runs, so input is held off too
  a_div_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    !cfg_ready |-> !in_tready)
    else $error("input taken during divide");

  // final frame: non-zero pixels carry the flag bit
  a_final_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] && (out_tdata != 16'h0000) |-> out_tdata[15])
    else $error("final-frame pixel without flag bit");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tlast) && $stable(out_tuser))
    else $error("stalled item changed");

endmodule

bind rgb555_fade_to_color_core rgbf_chk u_rgbf_chk (.*);
